FILE: src/whqs_pkg.sv
package whqs_pkg;

	localparam int WINDOW_SIZE_DEF = 64;

	localparam int SAMPLE_W   = 8;
	localparam int BIN_W      = 8;
	localparam int BIN_COUNT  = 256;
	localparam int HIST_W     = 9;
	localparam int CUM_W      = 10;
	localparam int HOP_W      = 11;
	localparam int HOP_CNT_W  = 10;
	localparam int RANK_W     = 9;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;

	localparam logic [BIN_W-1:0]     VALUE_OFFSET = 8'h80;
	localparam logic [BIN_W-1:0]     BIN_LAST     = 8'hFF;
	localparam logic [HIST_W-1:0]    HIST_SAT     = 9'h1FF;
	localparam logic [HOP_W-1:0]     HOP_MAX      = 11'd1024;
	localparam logic [HOP_W-1:0]     HOP_RESET    = 11'd64;
	localparam logic [RANK_W-1:0]    RANK_RESET   = 9'd32;

	localparam logic [CFG_IDX_W-1:0] CFG_HOP_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SELECT_RANK = 2'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OLD_RD,
		S_OLD_WR,
		S_NEW_RD,
		S_NEW_WR,
		S_WALK,
		S_WALK_TAIL,
		S_LOAD
	} whqs_state_t;

endpackage

FILE: src/window_histogram_quantile_stats.sv
// Sliding-window order statistics over a stream of signed 8-bit samples. The block holds the
// last WINDOW_SIZE samples in a ring and a 256-bin histogram of them; once the window is full,
// and then every hop_length samples, it emits median, IQR, min, max and the select_rank order
// statistic. A sample that gives no result occupies the block for its accept state and the
// read-modify-write states old read, old write, new read and new write on the histogram memory;
// a sample that gives a result then has the histogram walked one bin per cycle through its read
// port (a read of every bin, a drain state, a load state). The output register lets the next
// sample be taken while a result waits; a further result waits in the load state until the
// output register is free. Histogram bins are cleared at reset by per-bin valid bits.
module window_histogram_quantile_stats #(
	parameter int WINDOW_SIZE = whqs_pkg::WINDOW_SIZE_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [whqs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [whqs_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [whqs_pkg::SAMPLE_W-1:0]   sample,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [whqs_pkg::SAMPLE_W-1:0]   median_value,
	output logic [whqs_pkg::SAMPLE_W-1:0]          interquartile_range,
	output logic signed [whqs_pkg::SAMPLE_W-1:0]   window_min,
	output logic signed [whqs_pkg::SAMPLE_W-1:0]   window_max,
	output logic signed [whqs_pkg::SAMPLE_W-1:0]   ranked_value
);
	import whqs_pkg::*;

	localparam int PTR_W  = $clog2(WINDOW_SIZE);
	localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
	localparam int T_Q25  = WINDOW_SIZE / 4;
	localparam int T_MED  = WINDOW_SIZE / 2;
	localparam int T_Q75  = (WINDOW_SIZE * 3) / 4;

	whqs_state_t state_q, state_nxt;

	logic [HOP_W-1:0]     hop_length_q;
	logic [RANK_W-1:0]    select_rank_q;
	logic [PTR_W-1:0]     ptr_q;
	logic [FILL_W-1:0]    fill_q;
	logic [HOP_CNT_W-1:0] hop_cnt_q;
	logic [BIN_W-1:0]     bin_q;
	logic [BIN_W-1:0]     walk_addr_q;

	logic [SAMPLE_W-1:0]  ring_mem [WINDOW_SIZE];
	logic [SAMPLE_W-1:0]  ring_rd_q;
	logic [HIST_W-1:0]    hist_mem [BIN_COUNT];
	logic [HIST_W-1:0]    hist_rd_q;
	logic                 hist_rd_vld_q;
	logic [BIN_COUNT-1:0] hist_vld_q;

	logic                 proc_en_s1;
	logic [BIN_W-1:0]     proc_bin_s1;

	logic [CUM_W-1:0]     cum_q;
	logic                 got_min_q, got_q25_q, got_med_q, got_q75_q, got_rank_q;
	logic [BIN_W-1:0]     b_min_q, b_max_q, b_q25_q, b_med_q, b_q75_q, b_rank_q;

	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  median_q, iqr_q, min_q, max_q, rank_val_q;

	// combinational control
	logic                 accept;
	logic                 full;
	logic                 ring_we;
	logic                 hist_we;
	logic [BIN_W-1:0]     hist_raddr;
	logic [BIN_W-1:0]     hist_waddr;
	logic [HIST_W-1:0]    hist_wdata;
	logic [HIST_W-1:0]    hist_n;
	logic                 emit;
	logic                 walk_start;
	logic                 load;
	logic [HOP_W-1:0]     hop_eff;
	logic [HOP_W-1:0]     hop_next;
	logic [CUM_W-1:0]     rank_thr;
	logic [CUM_W-1:0]     cum_nxt;
	logic [CUM_W-1:0]     proc_n;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign full     = (fill_q == FILL_W'(WINDOW_SIZE));
	assign hist_n   = hist_rd_vld_q ? hist_rd_q : '0;
	assign load     = (state_q == S_LOAD) && (!out_valid_q || !out_stall);

	always_comb begin
		if (hop_length_q == '0) begin
			hop_eff = HOP_W'(1);
		end else if (hop_length_q > HOP_MAX) begin
			hop_eff = HOP_MAX;
		end else begin
			hop_eff = hop_length_q;
		end
		hop_next = {1'b0, hop_cnt_q} + HOP_W'(1);
		if ({1'b0, select_rank_q} > CUM_W'(WINDOW_SIZE)) begin
			rank_thr = CUM_W'(WINDOW_SIZE);
		end else begin
			rank_thr = {1'b0, select_rank_q};
		end
		if (full) begin
			emit = (hop_next >= hop_eff);
		end else begin
			emit = ((fill_q + FILL_W'(1)) == FILL_W'(WINDOW_SIZE));
		end
	end

	always_comb begin
		state_nxt  = state_q;
		ring_we    = 1'b0;
		hist_we    = 1'b0;
		hist_raddr = walk_addr_q;
		hist_waddr = bin_q;
		hist_wdata = hist_n;
		walk_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = S_OLD_RD;
				end
			end
			S_OLD_RD: begin
				// ring data is the sample leaving the window
				hist_raddr = ring_rd_q ^ VALUE_OFFSET;
				ring_we    = 1'b1;
				state_nxt  = S_OLD_WR;
			end
			S_OLD_WR: begin
				hist_waddr = ring_rd_q ^ VALUE_OFFSET;
				hist_wdata = hist_n - HIST_W'(1);
				hist_we    = full && (hist_n != '0);
				state_nxt  = S_NEW_RD;
			end
			S_NEW_RD: begin
				hist_raddr = bin_q;
				state_nxt  = S_NEW_WR;
			end
			S_NEW_WR: begin
				hist_waddr = bin_q;
				hist_wdata = (hist_n < HIST_SAT) ? hist_n + HIST_W'(1) : hist_n;
				hist_we    = 1'b1;
				walk_start = emit;
				state_nxt  = emit ? S_WALK : S_IDLE;
			end
			S_WALK: begin
				hist_raddr = walk_addr_q;
				if (walk_addr_q == BIN_LAST) begin
					state_nxt = S_WALK_TAIL;
				end
			end
			S_WALK_TAIL: begin
				state_nxt = S_LOAD;
			end
			S_LOAD: begin
				if (load) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_length_q  <= HOP_RESET;
			select_rank_q <= RANK_RESET;
		end else if (cfg_write) begin
			if (cfg_index == CFG_HOP_LENGTH) begin
				hop_length_q <= cfg_data;
			end else if (cfg_index == CFG_SELECT_RANK) begin
				select_rank_q <= cfg_data[RANK_W-1:0];
			end
		end
	end

	// window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			fill_q    <= '0;
			hop_cnt_q <= '0;
		end else begin
			if (ring_we) begin
				ptr_q <= (ptr_q == PTR_W'(WINDOW_SIZE - 1)) ? '0 : ptr_q + PTR_W'(1);
			end
			if (state_q == S_NEW_WR) begin
				if (!full) begin
					fill_q <= fill_q + FILL_W'(1);
					if (emit) begin
						hop_cnt_q <= '0;
					end
				end else if (emit) begin
					hop_cnt_q <= '0;
				end else begin
					hop_cnt_q <= hop_next[HOP_CNT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= sample ^ VALUE_OFFSET;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ptr_q] <= bin_q ^ VALUE_OFFSET;
		end
		ring_rd_q <= ring_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		hist_rd_q <= hist_mem[hist_raddr];
	end

	// a bin never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q    <= '0;
			hist_rd_vld_q <= 1'b0;
		end else begin
			if (hist_we) begin
				hist_vld_q[hist_waddr] <= 1'b1;
			end
			hist_rd_vld_q <= hist_vld_q[hist_raddr];
		end
	end

	// walk address and pipeline into the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_addr_q <= '0;
			proc_en_s1  <= 1'b0;
		end else begin
			if (walk_start) begin
				walk_addr_q <= '0;
			end else if (state_q == S_WALK) begin
				walk_addr_q <= walk_addr_q + BIN_W'(1);
			end
			proc_en_s1 <= (state_q == S_WALK);
		end
	end

	always_ff @(posedge clk) begin
		proc_bin_s1 <= walk_addr_q;
	end

	assign proc_n  = CUM_W'(hist_n);
	assign cum_nxt = cum_q + proc_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cum_q      <= '0;
			got_min_q  <= 1'b0;
			got_q25_q  <= 1'b0;
			got_med_q  <= 1'b0;
			got_q75_q  <= 1'b0;
			got_rank_q <= 1'b0;
		end else if (walk_start) begin
			cum_q      <= '0;
			got_min_q  <= 1'b0;
			got_q25_q  <= 1'b0;
			got_med_q  <= 1'b0;
			got_q75_q  <= 1'b0;
			got_rank_q <= 1'b0;
		end else if (proc_en_s1) begin
			cum_q <= cum_nxt;
			if (proc_n != '0) begin
				got_min_q <= 1'b1;
			end
			if (cum_nxt >= CUM_W'(T_Q25)) begin
				got_q25_q <= 1'b1;
			end
			if (cum_nxt >= CUM_W'(T_MED)) begin
				got_med_q <= 1'b1;
			end
			if (cum_nxt >= CUM_W'(T_Q75)) begin
				got_q75_q <= 1'b1;
			end
			if (cum_nxt >= rank_thr) begin
				got_rank_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (walk_start) begin
			b_min_q  <= '0;
			b_max_q  <= '0;
			b_q25_q  <= '0;
			b_med_q  <= '0;
			b_q75_q  <= '0;
			b_rank_q <= '0;
		end else if (proc_en_s1) begin
			if (proc_n != '0) begin
				b_max_q <= proc_bin_s1;
				if (!got_min_q) begin
					b_min_q <= proc_bin_s1;
				end
			end
			if (!got_q25_q && cum_nxt >= CUM_W'(T_Q25)) begin
				b_q25_q <= proc_bin_s1;
			end
			if (!got_med_q && cum_nxt >= CUM_W'(T_MED)) begin
				b_med_q <= proc_bin_s1;
			end
			if (!got_q75_q && cum_nxt >= CUM_W'(T_Q75)) begin
				b_q75_q <= proc_bin_s1;
			end
			if (!got_rank_q && cum_nxt >= rank_thr) begin
				b_rank_q <= proc_bin_s1;
			end
		end
	end

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			median_q   <= b_med_q ^ VALUE_OFFSET;
			iqr_q      <= b_q75_q - b_q25_q;
			min_q      <= b_min_q ^ VALUE_OFFSET;
			max_q      <= b_max_q ^ VALUE_OFFSET;
			rank_val_q <= b_rank_q ^ VALUE_OFFSET;
		end
	end

	assign out_valid           = out_valid_q;
	assign median_value        = median_q;
	assign interquartile_range = iqr_q;
	assign window_min          = min_q;
	assign window_max          = max_q;
	assign ranked_value        = rank_val_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_SIZE))
		else $error("fill count beyond window size");

	a_walk_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !proc_en_s1)
		else $error("histogram scan still running in idle");

	a_load_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_LOAD))
		else $error("result raised outside load state");

	a_emit_full: assert property (@(posedge clk) disable iff (!arst_n)
		walk_start |=> full)
		else $error("scan started before window full");

endmodule

FILE: tb/sv/tb_window_histogram_quantile_stats.sv
`timescale 1ns / 1ps

module tb_window_histogram_quantile_stats;

	import whqs_pkg::*;

	localparam int WIN          = WINDOW_SIZE_DEF;
	localparam int HOLD_CYCLES  = 3000;
	localparam int QUIET_LIMIT  = 20000;
	localparam int DRAIN_SETTLE = 16;
	localparam int END_SETTLE   = 300;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] med;
		logic [SAMPLE_W-1:0]        iqr;
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
		logic signed [SAMPLE_W-1:0] rnk;
	} window_stats_t;

	typedef enum logic {ROW_WRITE, ROW_BURST} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		logic [CFG_IDX_W-1:0]       idx;
		logic [CFG_DATA_W-1:0]      data;
		logic signed [SAMPLE_W-1:0] smp;
		int                         reps;
		bit                         typed;
		window_stats_t              want;
	} plan_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_write;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [SAMPLE_W-1:0]    sample;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [SAMPLE_W-1:0]    median_value;
	logic [SAMPLE_W-1:0]           interquartile_range;
	logic signed [SAMPLE_W-1:0]    window_min;
	logic signed [SAMPLE_W-1:0]    window_max;
	logic signed [SAMPLE_W-1:0]    ranked_value;

	window_histogram_quantile_stats #(
		.WINDOW_SIZE(WIN)
	) dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.sample             (sample),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.median_value       (median_value),
		.interquartile_range(interquartile_range),
		.window_min         (window_min),
		.window_max         (window_max),
		.ranked_value       (ranked_value)
	);

	// shadow of the block's window state
	logic [SAMPLE_W-1:0]   win_ring [WIN];
	logic [HIST_W-1:0]     bin_tally [BIN_COUNT];
	int unsigned           held;
	int unsigned           since_emit;
	int unsigned           wr_slot;
	logic [HOP_W-1:0]      hop_reg;
	logic [RANK_W-1:0]     rank_reg;

	window_stats_t         stats_due [$];
	plan_row_t             directed_rows [16];
	int                    error_count = 0;
	int                    quiet_cycles = 0;
	int                    send_idle_pct = 0;
	int                    recv_stall_pct = 0;
	int                    hold_seq = 0;
	int                    hold_seen = 0;
	int                    hold_left = 0;
	logic signed [SAMPLE_W-1:0] centre = '0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic log_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic window_stats_t scan_histogram();
		window_stats_t st;
		int unsigned cum;
		int unsigned thr;
		int b25, b50, b75, brk, bmin, bmax;
		thr = (rank_reg > WIN) ? WIN : 32'(rank_reg);
		cum = 0;
		b25 = -1; b50 = -1; b75 = -1; brk = -1; bmin = -1; bmax = -1;
		for (int j = 0; j < BIN_COUNT; j++) begin
			cum += 32'(bin_tally[j]);
			if (bin_tally[j] != 0) begin
				if (bmin < 0) bmin = j;
				bmax = j;
			end
			if (b25 < 0 && cum >= WIN / 4) b25 = j;
			if (b50 < 0 && cum >= WIN / 2) b50 = j;
			if (b75 < 0 && cum >= (WIN * 3) / 4) b75 = j;
			if (brk < 0 && cum >= thr) brk = j;
		end
		st.med = 8'(b50) ^ VALUE_OFFSET;
		st.iqr = 8'(b75 - b25);
		st.lo  = 8'(bmin) ^ VALUE_OFFSET;
		st.hi  = 8'(bmax) ^ VALUE_OFFSET;
		st.rnk = 8'(brk) ^ VALUE_OFFSET;
		return st;
	endfunction

	// Slide the window by one sample; report whether a result is due.
	task automatic advance_window(input logic signed [SAMPLE_W-1:0] s, output bit fired,
			output window_stats_t st);
		logic [BIN_W-1:0] old_bin;
		logic [BIN_W-1:0] new_bin;
		int unsigned hop;
		hop = 32'(hop_reg);
		if (hop == 0) hop = 1;
		if (hop > HOP_MAX) hop = 32'(HOP_MAX);
		fired = 1'b0;
		if (held >= WIN) begin
			old_bin = win_ring[wr_slot] ^ VALUE_OFFSET;
			if (bin_tally[old_bin] != 0) bin_tally[old_bin]--;
		end
		win_ring[wr_slot] = s;
		wr_slot = (wr_slot + 1) % WIN;
		new_bin = s ^ VALUE_OFFSET;
		if (bin_tally[new_bin] != HIST_SAT) bin_tally[new_bin]++;
		if (held < WIN) begin
			held++;
			if (held == WIN) begin
				fired = 1'b1;
				since_emit = 0;
			end
		end else if (since_emit + 1 >= hop) begin
			fired = 1'b1;
			since_emit = 0;
		end else begin
			since_emit = (since_emit + 1) & 10'h3FF;
		end
		st = fired ? scan_histogram() : '0;
	endtask

	// Entered and left at a falling edge; the valid stays high for a following beat.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
			input window_stats_t want);
		window_stats_t got;
		bit fired;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		advance_window(s, fired, got);
		if (fired) stats_due.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic drain(input int settle);
		in_valid <= 1'b0;
		while (stats_due.size() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == CFG_HOP_LENGTH) hop_reg = data;
		else if (idx == CFG_SELECT_RANK) rank_reg = data[RANK_W-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] v;
		case ($urandom_range(0, 3))
			0, 1: v = 8'($urandom_range(0, 255));
			2: v = centre + 8'($urandom_range(0, 15)) - 8'd8;
			default: begin
				case ($urandom_range(0, 3))
					0: v = 8'h80;
					1: v = 8'h7F;
					2: v = 8'h00;
					default: v = 8'hFF;
				endcase
			end
		endcase
		return v;
	endfunction

	// Receiver: random stalls, or one long hold-off when asked.
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		window_stats_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (stats_due.size() == 0) begin
				log_mismatch("result beat with nothing pending");
			end else begin
				want = stats_due.pop_front();
				if (median_value !== want.med)
					log_mismatch($sformatf("median_value %0d, want %0d", median_value, want.med));
				if (interquartile_range !== want.iqr)
					log_mismatch($sformatf("interquartile_range %0d, want %0d",
						interquartile_range, want.iqr));
				if (window_min !== want.lo)
					log_mismatch($sformatf("window_min %0d, want %0d", window_min, want.lo));
				if (window_max !== want.hi)
					log_mismatch($sformatf("window_max %0d, want %0d", window_max, want.hi));
				if (ranked_value !== want.rnk)
					log_mismatch($sformatf("ranked_value %0d, want %0d", ranked_value, want.rnk));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int n_items;
		int rank_pick;
		logic [CFG_DATA_W-1:0] hop_pick;
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		sample    = '0;
		out_stall = 1'b0;
		hop_reg   = HOP_RESET;
		rank_reg  = RANK_RESET;
		held = 0;
		since_emit = 0;
		wr_slot = 0;
		foreach (bin_tally[j]) bin_tally[j] = '0;

		directed_rows[0]  = '{ROW_BURST, CFG_HOP_LENGTH, 11'd0, -8'sd128, WIN, 1'b1,
			'{-8'sd128, 8'd0, -8'sd128, -8'sd128, -8'sd128}};
		// hop of zero behaves as one
		directed_rows[1]  = '{ROW_WRITE, CFG_HOP_LENGTH, 11'd0, 8'sd0, 0, 1'b0, '0};
		directed_rows[2]  = '{ROW_BURST, CFG_HOP_LENGTH, 11'd0, 8'sd127, WIN - 1, 1'b0, '0};
		directed_rows[3]  = '{ROW_BURST, CFG_HOP_LENGTH, 11'd0, 8'sd127, 1, 1'b1,
			'{8'sd127, 8'd0, 8'sd127, 8'sd127, 8'sd127}};
		// rank of zero picks the lowest bin
		directed_rows[4]  = '{ROW_WRITE, CFG_SELECT_RANK, 11'd0, 8'sd0, 0, 1'b0, '0};
		directed_rows[5]  = '{ROW_BURST, CFG_HOP_LENGTH, 11'd0, 8'sd127, 1, 1'b1,
			'{8'sd127, 8'd0, 8'sd127, 8'sd127, -8'sd128}};
		// rank beyond the window clamps to it, giving the maximum
		directed_rows[6]  = '{ROW_WRITE, CFG_SELECT_RANK, 11'h7FF, 8'sd0, 0, 1'b0, '0};
		directed_rows[7]  = '{ROW_BURST, CFG_HOP_LENGTH, 11'd0, -8'sd128, 1, 1'b1,
			'{8'sd127, 8'd0, -8'sd128, 8'sd127, 8'sd127}};
		directed_rows[8]  = '{ROW_WRITE, CFG_SELECT_RANK, 11'd1, 8'sd0, 0, 1'b0, '0};
		directed_rows[9]  = '{ROW_BURST, CFG_HOP_LENGTH, 11'd0, 8'sd0, 8, 1'b0, '0};
		// writes to indexes past the list are dropped
		directed_rows[10] = '{ROW_WRITE, CFG_SPARE_A, 11'h7FF, 8'sd0, 0, 1'b0, '0};
		directed_rows[11] = '{ROW_WRITE, CFG_SPARE_B, 11'd0, 8'sd0, 0, 1'b0, '0};
		directed_rows[12] = '{ROW_WRITE, CFG_SELECT_RANK, 11'd64, 8'sd0, 0, 1'b0, '0};
		directed_rows[13] = '{ROW_BURST, CFG_HOP_LENGTH, 11'd0, -8'sd1, 4, 1'b0, '0};
		directed_rows[14] = '{ROW_WRITE, CFG_HOP_LENGTH, 11'd3, 8'sd0, 0, 1'b0, '0};
		directed_rows[15] = '{ROW_BURST, CFG_HOP_LENGTH, 11'd0, 8'sd1, 6, 1'b0, '0};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain(DRAIN_SETTLE);
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				repeat (directed_rows[i].reps)
					send_sample(directed_rows[i].smp, directed_rows[i].typed,
						directed_rows[i].want);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain(DRAIN_SETTLE);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			n_items = 100;
			if (ph == 0) hop_pick = 11'd1;
			else if (ph == 3) begin
				// saturates to the longest hop; run long enough to see it fire
				hop_pick = 11'h7FF;
				n_items = 1100;
			end else if (ph == 6) hop_pick = 11'd0;
			else hop_pick = CFG_DATA_W'($urandom_range(2, 24));
			case ($urandom_range(0, 4))
				0: rank_pick = 0;
				1: rank_pick = 1;
				2: rank_pick = WIN;
				3: rank_pick = $urandom_range(WIN + 1, 511);
				default: rank_pick = $urandom_range(2, WIN - 1);
			endcase
			centre = 8'($urandom_range(0, 255));
			write_reg(CFG_HOP_LENGTH, hop_pick);
			write_reg(CFG_SELECT_RANK, {2'($urandom_range(0, 3)), 9'(rank_pick)});
			if (ph % 2 == 1)
				write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B,
					CFG_DATA_W'($urandom_range(0, 2047)));
			for (int k = 0; k < n_items; k++) begin
				// hold the output off while the sender keeps pushing, so the input backs up
				if (ph == 0 && k == 10) hold_seq <= hold_seq + 1;
				send_sample(pick_sample(), 1'b0, '0);
			end
		end

		drain(END_SETTLE);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: files.f
src/whqs_pkg.sv
src/window_histogram_quantile_stats.sv
tb/sv/tb_window_histogram_quantile_stats.sv
